/* rtl/upd_pkg.sv */
// Shared types, constants and character helpers for the URL percent decoder.
package upd_pkg;

  localparam int unsigned ByteW       = 8;
  localparam int unsigned PendDepth   = 5;
  localparam int unsigned ResMax      = 6;
  localparam int unsigned NumW        = 3;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [ByteW-1:0] CharPct   = 8'h25;
  localparam logic [ByteW-1:0] CharPlus  = 8'h2B;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharULow  = 8'h75;
  localparam logic [ByteW-1:0] CharUUp   = 8'h55;

  localparam logic [15:0] Utf8Max1 = 16'h007F;
  localparam logic [15:0] Utf8Max2 = 16'h07FF;
  localparam logic [ByteW-1:0] Utf8Lead2 = 8'hC0;
  localparam logic [ByteW-1:0] Utf8Lead3 = 8'hE0;
  localparam logic [ByteW-1:0] Utf8Cont  = 8'h80;

  // One request from the front to the back: the bytes it releases.
  typedef struct packed {
    logic [ResMax-1:0][ByteW-1:0] bytes;
    logic [NumW-1:0]              num;
    logic                         last;
  } cmd_t;

  function automatic logic hex_ok(input logic [ByteW-1:0] c);
    hex_ok = (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
  endfunction

  function automatic logic [3:0] hex_val(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] t;
    t = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      t = c - 8'h30;
    end else if (c inside {[8'h41:8'h46]}) begin
      t = c - 8'h37;
    end else if (c inside {[8'h61:8'h66]}) begin
      t = c - 8'h57;
    end
    hex_val = t[3:0];
  endfunction

  function automatic logic is_u(input logic [ByteW-1:0] c);
    is_u = (c == CharULow) || (c == CharUUp);
  endfunction

endpackage

/* rtl/url_percent_decoder.sv */
// Top level of the streaming URL percent decoder.
//
// Slave stream: one encoded character per request in s_axis_tdata_i, with
// s_axis_tlast_i on the last character of a string. Master stream: decoded
// bytes in m_axis_tdata_o, m_axis_tlast_o on the last decoded byte.
// '+' gives a space, %XX gives one byte, %uXXXX gives one to three UTF-8
// bytes; a broken escape passes its '%' literally and the bytes after it are
// decoded again, and an escape open at end of string is flushed literally.
// The front end accepts a character every cycle while the request queue has
// room; every character that does not open or extend an escape queues a
// request of one to six bytes. The back end sends one byte per cycle while
// the receiver is ready, so a request holds the output until its bytes are
// all sent; a byte is registered in the request queue before it can leave.
// When the receiver stalls, the queue fills and s_axis_tready_o drops.
// Reset empties the queue and clears any partly collected escape.
module url_percent_decoder
  import upd_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [ByteW-1:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic             s_axis_tlast_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [ByteW-1:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic             m_axis_tlast_o
);

  logic push, pop, q_full, q_valid;
  cmd_t cmd, head;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .q_full_i   (q_full),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push),
    .cmd_o      (cmd)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_byte_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

/* rtl/upd_front.sv */
// Front end: tracks the escape prefix and turns each input byte that does not open or extend an escape into a request.
module upd_front
  import upd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ByteW-1:0] in_byte_i,
  input  logic             in_last_i,
  input  logic             q_full_i,
  output logic             in_ready_o,
  output logic             push_o,
  output cmd_t             cmd_o
);

  logic [ByteW-1:0] pend_q [PendDepth];
  logic [NumW-1:0]  cnt_q, cnt_d;

  logic             accept;
  logic             hex_c, u_c, pend_u;
  logic             cont, done2, done5, hold, restart;
  logic [ByteW-1:0] cmap;
  logic [15:0]      cp;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && (cmd_o.num != '0);

  always_comb begin
    cmap   = (in_byte_i == CharPlus) ? CharSpace : in_byte_i;
    hex_c  = hex_ok(in_byte_i);
    u_c    = is_u(in_byte_i);
    pend_u = is_u(pend_q[1]);
    cont   = 1'b0;
    done2  = 1'b0;
    done5  = 1'b0;
    case (cnt_q)
      3'd1: cont = hex_c || u_c;
      3'd2: begin
        if (pend_u) begin
          cont = hex_c;
        end else begin
          done2 = hex_c;
        end
      end
      3'd3, 3'd4: cont = hex_c;
      3'd5: done5 = hex_c;
      default: cont = 1'b0;
    endcase
    hold    = cont && !in_last_i;
    restart = !cont && !done2 && !done5 && (in_byte_i == CharPct) && !in_last_i;
    cp      = {hex_val(pend_q[2]), hex_val(pend_q[3]), hex_val(pend_q[4]),
               hex_val(in_byte_i)};

    cmd_o.bytes = '0;
    cmd_o.num   = '0;
    cmd_o.last  = in_last_i;
    if (done2) begin
      cmd_o.bytes[0] = {hex_val(pend_q[1]), hex_val(in_byte_i)};
      cmd_o.num      = 3'd1;
    end else if (done5) begin
      if (cp <= Utf8Max1) begin
        cmd_o.bytes[0] = cp[7:0];
        cmd_o.num      = 3'd1;
      end else if (cp <= Utf8Max2) begin
        cmd_o.bytes[0] = Utf8Lead2 | {3'b000, cp[10:6]};
        cmd_o.bytes[1] = Utf8Cont | {2'b00, cp[5:0]};
        cmd_o.num      = 3'd2;
      end else begin
        cmd_o.bytes[0] = Utf8Lead3 | {4'b0000, cp[15:12]};
        cmd_o.bytes[1] = Utf8Cont | {2'b00, cp[11:6]};
        cmd_o.bytes[2] = Utf8Cont | {2'b00, cp[5:0]};
        cmd_o.num      = 3'd3;
      end
    end else if (!hold) begin
      // broken or flushed prefix goes out literally, then the new byte fresh unless it opens a new escape
      for (int i = 0; i < PendDepth; i++) begin
        cmd_o.bytes[i] = (NumW'(i) < cnt_q) ? pend_q[i] : cmap;
      end
      cmd_o.bytes[ResMax-1] = cmap;
      cmd_o.num = restart ? cnt_q : NumW'(cnt_q + 3'd1);
    end

    if (hold) begin
      cnt_d = NumW'(cnt_q + 3'd1);
    end else if (restart) begin
      cnt_d = 3'd1;
    end else begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < PendDepth; i++) begin
        if ((hold && cnt_q == NumW'(i)) || (restart && i == 0)) begin
          pend_q[i] <= in_byte_i;
        end
      end
    end
  end

endmodule

/* rtl/upd_queue.sv */
// Request queue between the front and back ends.
module upd_queue
  import upd_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  input  logic pop_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_q + 1'b1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_q + 1'b1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= CntW'(cnt_q + 1'b1);
      end else if (pop_i && !push_i) begin
        cnt_q <= CntW'(cnt_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

/* rtl/upd_back.sv */
// Back end: sends the bytes of the head request one per cycle while the receiver is ready.
module upd_back
  import upd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cmd_t             head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] out_byte_o,
  output logic             out_last_o
);

  logic [NumW-1:0] idx_q;
  logic            at_end, fire;

  assign at_end      = (idx_q == NumW'(head_i.num - 3'd1));
  assign fire        = q_valid_i && out_ready_i;
  assign pop_o       = fire && at_end;
  assign out_valid_o = q_valid_i;
  assign out_byte_o  = head_i.bytes[idx_q];
  assign out_last_o  = head_i.last && at_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (fire) begin
      idx_q <= at_end ? '0 : NumW'(idx_q + 3'd1);
    end
  end

endmodule

/* test/tb_url_percent_decoder.sv */
// Self-checking stream testbench for the URL percent decoder.
module tb_url_percent_decoder
  import upd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [ByteW-1:0] ch;
    logic             last;
    bit               wait_idle;
  } url_char_t;

  typedef struct {
    logic [ByteW-1:0] data;
    logic             last;
  } dec_byte_t;

  typedef enum int {
    TokPlain, TokPlus, TokHex, TokUni, TokBadPct, TokBadHex, TokBadUni
  } tok_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [ByteW-1:0] s_axis_tdata = '0;   // [7:0] in_byte
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [ByteW-1:0] m_axis_tdata;        // [7:0] out_byte
  logic             m_axis_tlast;

  url_char_t        url_chars[$];
  dec_byte_t        decoded_q[$];
  dec_byte_t        step_out[$];
  logic [ByteW-1:0] str_q[$];
  logic [ByteW-1:0] esc_buf[PendDepth];
  int               esc_len = 0;
  int               err_cnt = 0;
  int               chars_accepted = 0;

  url_percent_decoder DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // -1 when c is not a hex digit
  function automatic int nibble_of(input logic [ByteW-1:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  function automatic bit is_u_char(input logic [ByteW-1:0] c);
    return (c == CharULow) || (c == CharUUp);
  endfunction

  function automatic void release_byte(input logic [ByteW-1:0] b);
    dec_byte_t r;
    r.data = b;
    r.last = 1'b0;
    if (step_out.size() < ResMax) step_out.push_back(r);
  endfunction

  // Expected bytes released by one accepted character.
  function automatic void decode_char(input logic [ByteW-1:0] ch, input logic fin);
    logic [ByteW-1:0] scan[PendDepth+1];
    logic [15:0]      cp;
    int               n, p, avail, lim;
    bit               broken, waiting;
    step_out.delete();
    n = esc_len;
    for (int i = 0; i < n; i++) scan[i] = esc_buf[i];
    scan[n] = ch;
    n++;
    p = 0;
    while (p < n) begin
      avail = n - p;
      broken = 1'b0;
      waiting = 1'b0;
      if (scan[p] != CharPct) begin
        release_byte(scan[p] == CharPlus ? CharSpace : scan[p]);
        p++;
        continue;
      end
      if (avail < 2) begin
        waiting = 1'b1;
      end else if (nibble_of(scan[p+1]) >= 0) begin
        if (avail < 3) begin
          waiting = 1'b1;
        end else if (nibble_of(scan[p+2]) >= 0) begin
          release_byte({4'(nibble_of(scan[p+1])), 4'(nibble_of(scan[p+2]))});
          p += 3;
          continue;
        end else begin
          broken = 1'b1;
        end
      end else if (is_u_char(scan[p+1])) begin
        lim = (avail < 6) ? avail : 6;
        for (int i = 2; i < lim; i++) begin
          if (nibble_of(scan[p+i]) < 0) broken = 1'b1;
        end
        if (!broken) begin
          if (avail >= 6) begin
            cp = '0;
            for (int i = 2; i < 6; i++) cp = {cp[11:0], 4'(nibble_of(scan[p+i]))};
            if (cp <= Utf8Max1) begin
              release_byte(cp[7:0]);
            end else if (cp <= Utf8Max2) begin
              release_byte(Utf8Lead2 | {3'b000, cp[10:6]});
              release_byte(Utf8Cont | {2'b00, cp[5:0]});
            end else begin
              release_byte(Utf8Lead3 | {4'b0000, cp[15:12]});
              release_byte(Utf8Cont | {2'b00, cp[11:6]});
              release_byte(Utf8Cont | {2'b00, cp[5:0]});
            end
            p += 6;
            continue;
          end
          waiting = 1'b1;
        end
      end else begin
        broken = 1'b1;
      end
      if (waiting && !fin) break;
      // broken or flushed escape: the percent goes out as is, rescan after it
      release_byte(CharPct);
      p++;
    end
    esc_len = n - p;
    if (esc_len > PendDepth) esc_len = PendDepth;
    for (int i = 0; i < esc_len; i++) esc_buf[i] = scan[p+i];
    if (fin) begin
      esc_len = 0;
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    end
    foreach (step_out[i]) decoded_q.push_back(step_out[i]);
  endfunction

  function automatic logic [ByteW-1:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 10) return 8'("0") + 8'(v);
    return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [ByteW-1:0] rand_hex();
    return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
  endfunction

  function automatic logic [ByteW-1:0] rand_non_hex();
    logic [ByteW-1:0] c;
    do c = 8'($urandom_range(1, 255));
    while (nibble_of(c) >= 0 || is_u_char(c));
    return c;
  endfunction

  function automatic logic [ByteW-1:0] rand_u();
    return $urandom_range(0, 1) ? CharUUp : CharULow;
  endfunction

  task automatic add_char(input logic [ByteW-1:0] c, input logic last);
    url_char_t it;
    it.ch = c;
    it.last = last;
    it.wait_idle = 1'b0;
    url_chars.push_back(it);
  endtask

  task automatic add_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) add_char(s[i], fin && (i == s.len() - 1));
  endtask

  task automatic add_token();
    tok_e       kind;
    logic [15:0] cp;
    bit          upper;
    kind = tok_e'($urandom_range(0, 6));
    upper = 1'($urandom_range(0, 1));
    case (kind)
      TokPlain: begin
        repeat ($urandom_range(1, 3)) str_q.push_back(8'($urandom_range(1, 255)));
      end
      TokPlus: str_q.push_back(CharPlus);
      TokHex: begin
        str_q.push_back(CharPct);
        str_q.push_back(rand_hex());
        str_q.push_back(rand_hex());
      end
      TokUni: begin
        case ($urandom_range(0, 2))
          0:       cp = 16'($urandom_range(0, 16'h007F));
          1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom_range(0, 16'hFFFF));
        endcase
        str_q.push_back(CharPct);
        str_q.push_back(rand_u());
        for (int i = 3; i >= 0; i--) str_q.push_back(hex_char(cp[4*i+:4], upper));
      end
      TokBadPct: begin
        str_q.push_back(CharPct);
        str_q.push_back(rand_non_hex());
      end
      TokBadHex: begin
        str_q.push_back(CharPct);
        str_q.push_back(rand_hex());
        str_q.push_back(rand_non_hex());
      end
      default: begin
        str_q.push_back(CharPct);
        str_q.push_back(rand_u());
        repeat ($urandom_range(0, 3)) str_q.push_back(rand_hex());
        str_q.push_back(rand_non_hex());
      end
    endcase
  endtask

  // unfinished escape at end of string
  task automatic add_tail();
    str_q.push_back(CharPct);
    case ($urandom_range(0, 3))
      0: ;
      1: str_q.push_back(rand_hex());
      2: str_q.push_back(rand_u());
      default: begin
        str_q.push_back(rand_u());
        repeat ($urandom_range(1, 3)) str_q.push_back(rand_hex());
      end
    endcase
  endtask

  task automatic push_string(input bit wait_idle);
    url_char_t it;
    foreach (str_q[i]) begin
      it.ch = str_q[i];
      it.last = (i == str_q.size() - 1);
      it.wait_idle = wait_idle && (i == 0);
      url_chars.push_back(it);
    end
  endtask

  // sender: bursts with random gaps
  int gap_left;
  int burst_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tlast <= 1'b0;
      chars_accepted <= 0;
      gap_left = 0;
      burst_left = $urandom_range(1, 12);
      esc_len = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata, s_axis_tlast);
        void'(url_chars.pop_front());
        chars_accepted <= chars_accepted + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (url_chars.size() > 0 &&
                     !(url_chars[0].wait_idle && decoded_q.size() != 0)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= url_chars[0].ch;
          s_axis_tlast <= url_chars[0].last;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  int  hold_left;
  bit  hold_done;
  int  rx_mode;
  int  mode_left;
  int  rx_phase;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      rx_mode = 0;
      mode_left = 0;
      rx_phase = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && chars_accepted >= 60) begin
      hold_done = 1'b1;
      hold_left = 120;
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(16, 64);
      end
      mode_left--;
      rx_phase = (rx_phase + 1) % 3;
      case (rx_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (rx_phase != 0);
      endcase
    end
  end

  // output checker
  always @(posedge clk_i) begin
    dec_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        $error("unexpected output byte %02h last %0b", m_axis_tdata, m_axis_tlast);
        err_cnt++;
      end else begin
        want = decoded_q.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("out_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
          err_cnt++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("out_last: expected %0b, actual %0b", want.last, m_axis_tlast);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int str_idx;
    add_text("%00%fF+", 1'b1);
    add_text("%UFFFF", 1'b1);
    add_text("%zq", 1'b0);
    add_text("%u1x", 1'b0);
    add_char(8'h01, 1'b0);
    add_char(8'h00, 1'b0);
    add_char(8'hFF, 1'b0);
    add_text("%u1", 1'b1);
    str_idx = 0;
    while (url_chars.size() < 90) begin
      str_q.delete();
      repeat ($urandom_range(1, 8)) add_token();
      if ($urandom_range(0, 3) == 0) add_tail();
      push_string(str_idx == 0 || str_idx == 3);
      str_idx++;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (url_chars.size() != 0 || decoded_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
